>>> rtl/lpnu_pkg.sv
package lpnu_pkg;

  // command codes
  localparam logic [1:0] CMD_SRC  = 2'd0;
  localparam logic [1:0] CMD_SCAT = 2'd1;
  localparam logic [1:0] CMD_TEMP = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_STEP_TIME     = 2'd0;
  localparam logic [1:0] REG_HEAT_CAPACITY = 2'd1;
  localparam logic [1:0] REG_RAD_CONST     = 2'd2;
  localparam logic [1:0] REG_LIGHT_SPEED   = 2'd3;

  localparam int QW = 32;
  localparam int CFG_W = 31;
  // divider: one set-up stage, one stage per quotient bit, one output stage
  localparam int DIV_LAT = QW + 2;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                   ovf;
    logic signed [QW-1:0]   v;
  } q_t;

  function automatic q_t q_sat(input logic signed [63:0] x);
    q_t r;
    r.ovf = !((&x[63:QW-1]) || !(|x[63:QW-1]));
    r.v   = r.ovf ? (x[63] ? Q_MIN : Q_MAX) : x[QW-1:0];
    return r;
  endfunction

  // product, round half up, shift right by s, saturate
  function automatic q_t q_mul(input logic signed [QW-1:0] a,
                               input logic signed [QW-1:0] b, input int s);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + (64'sd1 <<< (s - 1));
    return q_sat(p >>> s);
  endfunction

  function automatic q_t q_add(input logic signed [QW-1:0] a,
                               input logic signed [QW-1:0] b);
    return q_sat(64'(a) + 64'(b));
  endfunction

  function automatic q_t q_sub(input logic signed [QW-1:0] a,
                               input logic signed [QW-1:0] b);
    return q_sat(64'(a) - 64'(b));
  endfunction

  function automatic q_t q_dbl(input logic signed [QW-1:0] a);
    return q_sat(64'(a) <<< 1);
  endfunction

endpackage

>>> rtl/linearized_planck_node_update_core.sv
// Pointwise node update for a linearised gray radiative transfer Newton step.
// Input channel (item_valid / item_stall): one transfer carries cmd and the six
// node fields. cmd 0 gives the emission source, 1 the effective scattering,
// 2 the updated temperature; cmd 3 gives value 0 with overflow clear.
// Output channel (result_valid / result_stall): one transfer per item, in order,
// with value (Q format) and overflow, which is set when any step of the chosen
// command saturated or divided by zero.
// Configuration: cfg_write with cfg_index / cfg_data; write only while idle.
// Throughput: one item per cycle while no output stall holds the pipeline.
// The pipeline depth is set by the chain g = dt/cv, then alpha, then the second
// division; each division runs through a 34-stage bit-per-stage divider.
// The whole pipeline advances together; when the output holds a result and
// result_stall is high, every stage holds and item_stall rises.
// Reset (rst, synchronous) clears all valid bits and loads 1.0 into all four
// registers; no result is lost or repeated under any stall pattern.
module linearized_planck_node_update_core import lpnu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            cmd,
  input  logic signed [QW-1:0]  temp_now,
  input  logic signed [QW-1:0]  temp_prev,
  input  logic signed [QW-1:0]  sigma_abs,
  input  logic signed [QW-1:0]  sigma_scat,
  input  logic signed [QW-1:0]  angular_prev,
  input  logic signed [QW-1:0]  scalar_flux,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [QW-1:0]  value,
  output logic                  overflow
);

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [QW-1:0] t, tp, sa, ss, psi, phi;
    logic signed [QW-1:0] ac, t2, t3, t4, dpl, pl, dtc;
    logic signed [QW-1:0] sd, sdt, num, den, diff;
    logic signed [QW-1:0] g, src, gs, kk, em, term;
    logic signed [QW-1:0] alpha, inner, numer, q, lin, br, res;
    logic                 ovf;
  } pipe_t;

  // stage positions, tied to the divider depth
  localparam int S_GQ = DIV_LAT + 1;   // g out of the first divider
  localparam int S_GS = S_GQ + 1;      // gs; source quotient arrives
  localparam int S_K  = S_GS + 1;
  localparam int S_AL = S_K + 1;       // alpha; feeds the second division
  localparam int S_Q  = S_AL + DIV_LAT + 1;
  localparam int S_F1 = S_Q + 1;
  localparam int S_F2 = S_F1 + 1;
  localparam int S_F3 = S_F2 + 1;
  localparam int NST  = S_F3 + 1;      // output register

  localparam logic signed [QW-1:0] ONE = QW'(64'd1 << FRAC_BITS);

  logic [CFG_W-1:0] step_time, heat_capacity, rad_const, light_speed;
  logic signed [QW-1:0] dt_s, cv_s, ra_s, lc_s;

  assign dt_s = $signed({1'b0, step_time});
  assign cv_s = $signed({1'b0, heat_capacity});
  assign ra_s = $signed({1'b0, rad_const});
  assign lc_s = $signed({1'b0, light_speed});

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time     <= CFG_W'(64'd1 << FRAC_BITS);
      heat_capacity <= CFG_W'(64'd1 << FRAC_BITS);
      rad_const     <= CFG_W'(64'd1 << FRAC_BITS);
      light_speed   <= CFG_W'(64'd1 << FRAC_BITS);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_TIME:     step_time     <= cfg_data;
        REG_HEAT_CAPACITY: heat_capacity <= cfg_data;
        REG_RAD_CONST:     rad_const     <= cfg_data;
        REG_LIGHT_SPEED:   light_speed   <= cfg_data;
        default: ;
      endcase
    end
  end

  pipe_t p [0:NST];
  logic  v [0:NST];
  logic  adv;
  pipe_t p_in;

  // advance everything unless a finished result is held back
  assign adv        = !(v[NST] && result_stall);
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv) v[0] <= item_valid;
  end

  always_comb begin
    p_in     = '0;
    p_in.cmd = cmd;
    p_in.t   = temp_now;
    p_in.tp  = temp_prev;
    p_in.sa  = sigma_abs;
    p_in.ss  = sigma_scat;
    p_in.psi = angular_prev;
    p_in.phi = scalar_flux;
  end

  always_ff @(posedge clk) begin
    if (adv) p[0] <= p_in;
  end

  // dividers: g = dt/cv, src = psi/(dt*c), and the late shared division
  logic signed [QW-1:0] g_quo, s_quo, l_quo, l_num, l_den;
  logic                 g_ovf, s_ovf, l_ovf;

  lpnu_div #(.FRAC_BITS(FRAC_BITS)) u_div_g (
    .clk(clk), .en(adv), .num(dt_s), .den(cv_s), .quo(g_quo), .ovf(g_ovf)
  );

  lpnu_div #(.FRAC_BITS(FRAC_BITS)) u_div_src (
    .clk(clk), .en(adv), .num(p[1].psi), .den(p[1].dtc), .quo(s_quo), .ovf(s_ovf)
  );

  // scattering: num/den; source: dpl/alpha; temperature: numer/alpha
  always_comb begin
    case (p[S_AL].cmd)
      CMD_SCAT: begin
        l_num = p[S_AL].num;
        l_den = p[S_AL].den;
      end
      CMD_SRC: begin
        l_num = p[S_AL].dpl;
        l_den = p[S_AL].alpha;
      end
      default: begin
        l_num = p[S_AL].numer;
        l_den = p[S_AL].alpha;
      end
    endcase
  end

  lpnu_div #(.FRAC_BITS(FRAC_BITS)) u_div_late (
    .clk(clk), .en(adv), .num(l_num), .den(l_den), .quo(l_quo), .ovf(l_ovf)
  );

  for (genvar k = 1; k <= NST; k++) begin : g_st
    pipe_t nx;

    always_comb begin
      q_t   a, b, c, d;
      logic c0, c1, c2, c02;
      nx  = p[k-1];
      c0  = (nx.cmd == CMD_SRC);
      c1  = (nx.cmd == CMD_SCAT);
      c2  = (nx.cmd == CMD_TEMP);
      c02 = c0 || c2;
      a = '0;
      b = '0;
      c = '0;
      d = '0;
      case (k)
        1: begin
          a = q_mul(ra_s, lc_s, FRAC_BITS);
          b = q_mul(nx.t, nx.t, FRAC_BITS);
          c = q_mul(dt_s, lc_s, FRAC_BITS);
          nx.ac  = a.v;
          nx.t2  = b.v;
          nx.dtc = c.v;
          nx.ovf = nx.ovf | a.ovf | b.ovf | (c.ovf & c0);
        end
        2: begin
          a = q_mul(nx.t2, nx.t, FRAC_BITS);
          nx.t3  = a.v;
          nx.ovf = nx.ovf | a.ovf;
        end
        3: begin
          a = q_mul(nx.t3, nx.t, FRAC_BITS);
          b = q_mul(nx.ac, nx.t3, FRAC_BITS - 1);
          nx.t4  = a.v;
          nx.dpl = b.v;
          nx.ovf = nx.ovf | (a.ovf & c02) | b.ovf;
        end
        4: begin
          a = q_mul(nx.ac, nx.t4, FRAC_BITS + 1);
          b = q_mul(nx.sa, nx.dpl, FRAC_BITS);
          nx.pl  = a.v;
          nx.sd  = b.v;
          nx.ovf = nx.ovf | (a.ovf & c02) | (b.ovf & c1);
        end
        5: begin
          a = q_mul(nx.sd, dt_s, FRAC_BITS);
          b = q_dbl(nx.pl);
          c = q_sub(nx.phi, b.v);
          nx.sdt  = a.v;
          nx.diff = c.v;
          nx.ovf  = nx.ovf | (a.ovf & c1) | ((b.ovf | c.ovf) & c2);
        end
        6: begin
          a = q_dbl(nx.sdt);
          b = q_add(cv_s, a.v);
          nx.num = a.v;
          nx.den = b.v;
          nx.ovf = nx.ovf | ((a.ovf | b.ovf) & c1);
        end
        S_GQ: begin
          nx.g   = g_quo;
          nx.ovf = nx.ovf | (g_ovf & c02);
        end
        S_GS: begin
          a = q_mul(nx.g, nx.sa, FRAC_BITS);
          nx.gs  = a.v;
          nx.src = s_quo;
          nx.ovf = nx.ovf | (a.ovf & c02) | (s_ovf & c0);
        end
        S_K: begin
          a = q_mul(nx.gs, nx.dpl, FRAC_BITS);
          b = q_dbl(a.v);
          c = q_mul(nx.gs, nx.pl, FRAC_BITS);
          d = q_dbl(c.v);
          nx.kk  = b.v;
          nx.em  = d.v;
          nx.ovf = nx.ovf | ((a.ovf | b.ovf) & c02) | ((c.ovf | d.ovf) & c0);
          a = q_mul(nx.gs, nx.diff, FRAC_BITS);
          nx.term = a.v;
          nx.ovf  = nx.ovf | (a.ovf & c2);
        end
        S_AL: begin
          a = q_add(ONE, nx.kk);
          b = q_sub(nx.tp, nx.t);
          c = q_sub(b.v, nx.em);
          d = q_add(b.v, nx.term);
          nx.alpha = a.v;
          nx.inner = c.v;
          nx.numer = d.v;
          nx.ovf   = nx.ovf | ((a.ovf | b.ovf) & c02) | (c.ovf & c0) | (d.ovf & c2);
        end
        S_Q: begin
          nx.q   = l_quo;
          nx.ovf = nx.ovf | l_ovf;
        end
        S_F1: begin
          a = q_mul(nx.q, nx.inner, FRAC_BITS);
          b = q_mul(nx.q, nx.sa, FRAC_BITS);
          c = q_add(nx.ss, b.v);
          d = q_add(nx.t, nx.q);
          nx.lin = a.v;
          nx.res = c1 ? c.v : d.v;
          nx.ovf = nx.ovf | (a.ovf & c0) | ((b.ovf | c.ovf) & c1) | (d.ovf & c2);
        end
        S_F2: begin
          a = q_add(nx.pl, nx.lin);
          nx.br  = a.v;
          nx.ovf = nx.ovf | (a.ovf & c0);
        end
        S_F3: begin
          a = q_mul(nx.sa, nx.br, FRAC_BITS);
          b = q_add(nx.src, a.v);
          if (c0) nx.res = b.v;
          nx.ovf = nx.ovf | ((a.ovf | b.ovf) & c0);
        end
        NST: begin
          // unused command: drop whatever was accumulated
          if (nx.cmd == CMD_NONE) begin
            nx.res = '0;
            nx.ovf = 1'b0;
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) v[k] <= 1'b0;
      else if (adv) v[k] <= v[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) p[k] <= nx;
    end
  end

  assign result_valid = v[NST];
  assign value        = p[NST].res;
  assign overflow     = p[NST].ovf;

endmodule

>>> rtl/lpnu_div.sv
module lpnu_div import lpnu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [QW-1:0] num,
  input  logic signed [QW-1:0] den,
  output logic signed [QW-1:0] quo,
  output logic                 ovf
);

  logic [63:0]   rem  [0:QW];
  logic [QW-1:0] qb   [0:QW];
  logic [QW-1:0] dm   [0:QW];
  logic          neg  [0:QW];
  logic          npos [0:QW];
  logic          nneg [0:QW];
  logic          dz   [0:QW];
  logic          big  [0:QW];

  logic [QW-1:0] nabs, dabs;
  logic [63:0]   nsh;

  assign nabs = num[QW-1] ? QW'(-num) : QW'(num);
  assign dabs = den[QW-1] ? QW'(-den) : QW'(den);
  assign nsh  = 64'(nabs) << FRAC_BITS;

  // set up magnitudes; a quotient of 2^32 or more is caught here
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= nsh;
      qb[0]   <= '0;
      dm[0]   <= dabs;
      neg[0]  <= num[QW-1] ^ den[QW-1];
      npos[0] <= !num[QW-1] && (num != '0);
      nneg[0] <= num[QW-1];
      dz[0]   <= (den == '0);
      big[0]  <= nsh >= {dabs, 32'd0};
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_bit
    logic [64:0] trial;
    assign trial = {1'b0, rem[i-1]} - ({33'd0, dm[i-1]} << (QW - i));
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= trial[64] ? rem[i-1] : trial[63:0];
        qb[i]   <= trial[64] ? qb[i-1] : (qb[i-1] | (QW'(1) << (QW - i)));
        dm[i]   <= dm[i-1];
        neg[i]  <= neg[i-1];
        npos[i] <= npos[i-1];
        nneg[i] <= nneg[i-1];
        dz[i]   <= dz[i-1];
        big[i]  <= big[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz[QW]) begin
        ovf <= 1'b1;
        quo <= npos[QW] ? Q_MAX : (nneg[QW] ? Q_MIN : '0);
      end else if (!neg[QW]) begin
        ovf <= big[QW] || qb[QW][QW-1];
        quo <= (big[QW] || qb[QW][QW-1]) ? Q_MAX : $signed(qb[QW]);
      end else begin
        ovf <= big[QW] || (qb[QW] > 32'h8000_0000);
        quo <= (big[QW] || (qb[QW] > 32'h8000_0000)) ? Q_MIN : $signed(QW'(-qb[QW]));
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lpnu_pkg::*;

  typedef logic signed [31:0] q32;
  localparam q32 ONE = 32'sh0001_0000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE = 100;

  // Holds the expected stream of node results, oldest first.
  class node_result_board;
    q32 exp_value[$];
    bit exp_ovf[$];
    int errors;
    int compared;

    function void note(q32 v, bit o);
      exp_value.push_back(v);
      exp_ovf.push_back(o);
    endfunction

    function void check(q32 v, bit o);
      q32 ev;
      bit eo;
      if (exp_value.size() == 0) begin
        $error("result with no expectation waiting: value %h overflow %b", v, o);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      eo = exp_ovf.pop_front();
      compared++;
      if (v !== ev) begin
        $error("value: expected %h, got %h", ev, v);
        errors++;
      end
      if (o !== eo) begin
        $error("overflow: expected %b, got %b", eo, o);
        errors++;
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic [1:0] cmd;
  q32 temp_now, temp_prev, sigma_abs, sigma_scat, angular_prev, scalar_flux;
  logic result_valid;
  logic result_stall;
  q32 value;
  logic overflow;

  linearized_planck_node_update_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .temp_now(temp_now), .temp_prev(temp_prev),
    .sigma_abs(sigma_abs), .sigma_scat(sigma_scat),
    .angular_prev(angular_prev), .scalar_flux(scalar_flux),
    .result_valid(result_valid), .result_stall(result_stall),
    .value(value), .overflow(overflow)
  );

  node_result_board board = new();

  // Shadow copy of the four registers.
  logic [CFG_W-1:0] dt_reg, cv_reg, a_reg, c_reg;

  bit long_hold_req;   // receiver: hold off for a long stretch
  bit calm;            // both sides: no idling
  int idle_cycles;
  int items_sent;
  int phases_run;

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic, saturating, with a sticky overflow flag
  // ---------------------------------------------------------------------
  function automatic q32 fx_sat(longint x, inout bit o);
    if (x > 64'sh7FFF_FFFF) begin
      o = 1;
      return Q_MAX;
    end
    if (x < -64'sh8000_0000) begin
      o = 1;
      return Q_MIN;
    end
    return q32'(x);
  endfunction

  // product rounded half up, shifted by s
  function automatic q32 fx_mul(q32 a, q32 b, int s, inout bit o);
    longint p;
    p = longint'(a) * longint'(b);
    p = p + (longint'(1) <<< (s - 1));
    return fx_sat(p >>> s, o);
  endfunction

  function automatic q32 fx_div(q32 n, q32 d, inout bit o);
    if (d == 0) begin
      o = 1;
      if (n > 0) return Q_MAX;
      if (n < 0) return Q_MIN;
      return 0;
    end
    return fx_sat((longint'(n) * 65536) / longint'(d), o);
  endfunction

  function automatic q32 fx_add(q32 a, q32 b, inout bit o);
    return fx_sat(longint'(a) + longint'(b), o);
  endfunction

  function automatic q32 fx_sub(q32 a, q32 b, inout bit o);
    return fx_sat(longint'(a) - longint'(b), o);
  endfunction

  function automatic q32 fx_dbl(q32 a, inout bit o);
    return fx_sat(longint'(a) * 2, o);
  endfunction

  // Work out the node result for one transfer under the shadow registers.
  task automatic predict_node(input logic [1:0] op, input q32 t, tp, sa, ss, psi, phi);
    bit o;
    q32 dt, cv, a, c, ac, t2, t3, t4, dpl, pl, g, gs, k, alpha, res;
    q32 num, den, nu, src, em, inner, lin, br, diff, term, numer;
    o = 0;
    res = 0;
    dt = q32'({1'b0, dt_reg});
    cv = q32'({1'b0, cv_reg});
    a = q32'({1'b0, a_reg});
    c = q32'({1'b0, c_reg});
    if (op != CMD_NONE) begin
      ac = fx_mul(a, c, 16, o);
      t2 = fx_mul(t, t, 16, o);
      t3 = fx_mul(t2, t, 16, o);
      dpl = fx_mul(ac, t3, 15, o);
      if (op == CMD_SCAT) begin
        num = fx_dbl(fx_mul(fx_mul(sa, dpl, 16, o), dt, 16, o), o);
        den = fx_add(cv, num, o);
        nu = fx_div(num, den, o);
        res = fx_add(ss, fx_mul(nu, sa, 16, o), o);
      end else begin
        t4 = fx_mul(t3, t, 16, o);
        pl = fx_mul(ac, t4, 17, o);
        g = fx_div(dt, cv, o);
        gs = fx_mul(g, sa, 16, o);
        k = fx_dbl(fx_mul(gs, dpl, 16, o), o);
        alpha = fx_add(ONE, k, o);
        if (op == CMD_SRC) begin
          src = fx_div(psi, fx_mul(dt, c, 16, o), o);
          em = fx_dbl(fx_mul(gs, pl, 16, o), o);
          inner = fx_sub(fx_sub(tp, t, o), em, o);
          lin = fx_mul(fx_div(dpl, alpha, o), inner, 16, o);
          br = fx_add(pl, lin, o);
          res = fx_add(src, fx_mul(sa, br, 16, o), o);
        end else begin
          diff = fx_sub(phi, fx_dbl(pl, o), o);
          term = fx_mul(gs, diff, 16, o);
          numer = fx_add(fx_sub(tp, t, o), term, o);
          res = fx_add(t, fx_div(numer, alpha, o), o);
        end
      end
    end
    board.note(res, o);
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset, monitors, watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge; inputs move only at the falling edge.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      predict_node(cmd, temp_now, temp_prev, sigma_abs, sigma_scat, angular_prev,
                   scalar_flux);
    if (!rst && result_valid && !result_stall)
      board.check(value, overflow);
  end

  // Count cycles with no transfer on either side while work is outstanding.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (board.pending() == 0 && !item_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("linearized_planck_node_update_core: mismatch");
        $finish;
      end
    end
  end

  // Receiver: idle a random number of cycles per result, or hold off long on request.
  initial begin
    int n;
    result_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        result_stall <= 1;
        repeat (300) @(negedge clk);
        long_hold_req = 0;
      end
      n = calm ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        result_stall <= 1;
        repeat (n) @(negedge clk);
      end
      result_stall <= 0;
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Sender tasks (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------
  task automatic send_node(input logic [1:0] op, input q32 t, tp, sa, ss, psi, phi);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1;
    cmd <= op;
    temp_now <= t;
    temp_prev <= tp;
    sigma_abs <= sa;
    sigma_scat <= ss;
    angular_prev <= psi;
    scalar_flux <= phi;
    do @(posedge clk); while (!(item_valid && !item_stall));
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait for every expected result, then let the pipe settle.
  task automatic drain_node_pipe();
    item_valid <= 0;
    while (board.pending() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] dt, cv, a, c);
    logic [CFG_W-1:0] vals [4];
    logic [1:0] idx [4];
    vals = '{dt, cv, a, c};
    idx = '{REG_STEP_TIME, REG_HEAT_CAPACITY, REG_RAD_CONST, REG_LIGHT_SPEED};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_write <= 0;
    dt_reg = dt;
    cv_reg = cv;
    a_reg = a;
    c_reg = c;
    @(negedge clk);
  endtask

  // Mix of full-range values, values near 1.0 and the extremes.
  function automatic q32 pick_q();
    case ($urandom_range(0, 9))
      0, 1, 2: return q32'($urandom);
      3:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      4:       return q32'($urandom_range(0, 3)) - 1;
      default: return q32'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg(bit nonzero);
    logic [CFG_W-1:0] r;
    case ($urandom_range(0, 3))
      0:       r = CFG_W'($urandom);
      1:       r = CFG_W'($urandom_range(0, 32'h0001_0000));
      default: r = CFG_W'($urandom_range(32'h0000_4000, 32'h0004_0000));
    endcase
    if (nonzero && r == 0) r = 1;
    return r;
  endfunction

  task automatic random_nodes(input int count);
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 15) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
      send_node(op, pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q());
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = REG_STEP_TIME;
    cfg_data = '0;
    item_valid = 0;
    cmd = CMD_SRC;
    temp_now = 0;
    temp_prev = 0;
    sigma_abs = 0;
    sigma_scat = 0;
    angular_prev = 0;
    scalar_flux = 0;
    long_hold_req = 0;
    calm = 0;
    items_sent = 0;
    phases_run = 0;
    dt_reg = 31'h0001_0000;
    cv_reg = 31'h0001_0000;
    a_reg = 31'h0001_0000;
    c_reg = 31'h0001_0000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset values: every command, field extremes, alpha and the nu
    // denominator driven to zero (T = 1.0, sa = -0.25).
    for (int op = 0; op < 4; op++)
      send_node(2'(op), ONE, ONE / 2, ONE, ONE, ONE, ONE);
    send_node(CMD_SRC, 32'sh0001_0000, 0, -32'sh0000_4000, 0, ONE, ONE);
    send_node(CMD_SCAT, 32'sh0001_0000, 0, -32'sh0000_4000, ONE, 0, 0);
    send_node(CMD_TEMP, 32'sh0001_0000, 0, -32'sh0000_4000, 0, 0, ONE);
    send_node(CMD_TEMP, 32'sh0001_0000, 0, -32'sh0000_4000, 0, 0, -ONE);
    send_node(CMD_SRC, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_node(CMD_SRC, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_node(CMD_SCAT, Q_MAX, 0, Q_MIN, Q_MAX, 0, 0);
    send_node(CMD_SCAT, Q_MIN, 0, Q_MAX, Q_MIN, 0, 0);
    send_node(CMD_TEMP, Q_MAX, Q_MIN, Q_MAX, 0, 0, Q_MAX);
    send_node(CMD_TEMP, 0, 0, 0, 0, 0, 0);
    send_node(CMD_SRC, 0, 0, 0, 0, 0, 0);
    send_node(CMD_NONE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_node(CMD_NONE, -1, -1, -1, -1, -1, -1);
    random_nodes(60);
    drain_node_pipe();
    phases_run++;

    // Zero time step: dt*c vanishes in the emission source.
    write_regs('0, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000);
    send_node(CMD_SRC, ONE, ONE, ONE, 0, ONE, 0);
    send_node(CMD_SRC, ONE, ONE, ONE, 0, -ONE, 0);
    send_node(CMD_SRC, ONE, ONE, ONE, 0, 0, 0);
    random_nodes(60);
    drain_node_pipe();
    phases_run++;

    // All registers at their top; the receiver holds off so the pipe fills.
    write_regs('1, '1, '1, '1);
    long_hold_req = 1;
    random_nodes(120);
    drain_node_pipe();
    phases_run++;

    // Bottom values: smallest cv and c, no radiation constant, no idling.
    calm = 1;
    write_regs(31'h0000_8000, 31'd1, '0, 31'd1);
    random_nodes(70);
    drain_node_pipe();
    calm = 0;
    phases_run++;

    // Random register settings.
    for (int p = 0; p < 4; p++) begin
      write_regs(pick_reg(0), pick_reg(1), pick_reg(0), pick_reg(1));
      random_nodes(50);
      drain_node_pipe();
      phases_run++;
    end

    $display("sent %0d node items over %0d register settings, %0d results compared",
             items_sent, phases_run, board.compared);
    $display("covered all commands, saturation, zero divisors and long output stalls");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("linearized_planck_node_update_core: match");
    end else begin
      $display("linearized_planck_node_update_core: mismatch");
    end
    $finish;
  end

endmodule
